>>> hw/rtl/skv_pkg.sv
package skv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CFG_W = 6;

    // request kinds
    localparam logic [1:0] KIND_GET   = 2'd0;
    localparam logic [1:0] KIND_PUT   = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // cell operations
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_PUT  = 2'd1;
    localparam logic [1:0] CELL_MARK = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] req_key;
        logic [VAL_W-1:0] req_value;
        logic [KEY_W-1:0] req_end;
    } cell_ctrl_t;

    // per cell status back to the sequencer
    typedef struct packed {
        logic lt;
        logic eq;
        logic in_rng;
        logic mark;
    } cell_stat_t;

endpackage

>>> hw/rtl/skv_cell.sv
module skv_cell
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  skv_pkg::cell_ctrl_t     ctrl,
    // key already stored somewhere in the row
    input  logic                    upd,
    input  logic                    occ,
    // lower neighbor, used on insert
    input  logic                    prev_lt,
    input  logic [skv_pkg::KEY_W-1:0] prev_key,
    input  logic [skv_pkg::VAL_W-1:0] prev_value,
    // upper neighbor, used on rotate
    input  logic [skv_pkg::KEY_W-1:0] next_key,
    input  logic [skv_pkg::VAL_W-1:0] next_value,
    input  logic                    next_mark,
    output logic [skv_pkg::KEY_W-1:0] cell_key,
    output logic [skv_pkg::VAL_W-1:0] cell_value,
    output skv_pkg::cell_stat_t     stat
);

    logic [skv_pkg::KEY_W-1:0] key_reg;
    logic [skv_pkg::KEY_W-1:0] key_next;
    logic [skv_pkg::VAL_W-1:0] value_reg;
    logic [skv_pkg::VAL_W-1:0] value_next;
    logic                      mark_reg;
    logic                      mark_next;
    logic                      lt;
    logic                      eq;
    logic                      in_rng;

    // local compares against the broadcast request
    always_comb
    begin
        lt     = occ && ($signed(key_reg) < $signed(ctrl.req_key));
        eq     = occ && (key_reg == ctrl.req_key);
        in_rng = occ && !($signed(key_reg) < $signed(ctrl.req_key))
                     && !($signed(ctrl.req_end) < $signed(key_reg));
    end

    // next contents per operation
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        mark_next  = mark_reg;
        case (ctrl.op)
            skv_pkg::CELL_PUT:
            begin
                if (upd)
                begin
                    if (eq)
                    begin
                        value_next = ctrl.req_value;
                    end
                end
                else if (!lt)
                begin
                    if (prev_lt)
                    begin
                        key_next   = ctrl.req_key;
                        value_next = ctrl.req_value;
                    end
                    else
                    begin
                        key_next   = prev_key;
                        value_next = prev_value;
                    end
                end
            end
            skv_pkg::CELL_MARK:
            begin
                mark_next = in_rng;
            end
            skv_pkg::CELL_ROT:
            begin
                key_next   = next_key;
                value_next = next_value;
                mark_next  = next_mark;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    // range mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    assign cell_key    = key_reg;
    assign cell_value  = value_reg;
    assign stat.lt     = lt;
    assign stat.eq     = eq;
    assign stat.in_rng = in_rng;
    assign stat.mark   = mark_reg;

endmodule

>>> hw/rtl/sorted_kv_buffer_top.sv
// get, put, clear: EXEC's result is registered; a new start is taken only in IDLE
// range: a mark step in EXEC, then ROT turns the cell row once through every cell;
//   matching entries leave one per cycle as they pass cell 0; busy until ROT ends
// an empty range gives its single result from EXEC, with no rotation
// reset empties the store and sets limit_reg to 32; results are not stalled
module sorted_kv_buffer_top
#(
    parameter int CAPACITY = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                kind,
    input  logic signed [31:0]        key,
    input  logic signed [31:0]        value,
    input  logic signed [31:0]        range_end,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [5:0]                cfg_data,
    output logic                      result_valid,
    output logic                      hit,
    output logic signed [31:0]        out_key,
    output logic signed [31:0]        out_value,
    output logic                      last
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int RCW = $clog2(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_ROT  = 2'd2;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [RCW-1:0]                   rot_reg;
    logic [RCW-1:0]                   rot_next;
    logic [skv_pkg::CFG_W-1:0]        limit_reg;
    logic [1:0]                       kind_reg;
    logic [skv_pkg::KEY_W-1:0]        req_key_reg;
    logic [skv_pkg::VAL_W-1:0]        req_value_reg;
    logic [skv_pkg::KEY_W-1:0]        req_end_reg;
    logic                             res_valid_reg;
    logic                             res_valid_next;
    logic                             hit_reg;
    logic                             hit_next;
    logic [skv_pkg::KEY_W-1:0]        res_key_reg;
    logic [skv_pkg::KEY_W-1:0]        res_key_next;
    logic [skv_pkg::VAL_W-1:0]        res_value_reg;
    logic [skv_pkg::VAL_W-1:0]        res_value_next;
    logic                             last_reg;
    logic                             last_next;

    skv_pkg::cell_ctrl_t              ctrl;
    skv_pkg::cell_stat_t              stat [CAPACITY];
    logic [skv_pkg::KEY_W-1:0]        cell_key [CAPACITY];
    logic [skv_pkg::VAL_W-1:0]        cell_value [CAPACITY];
    logic [CAPACITY-1:0]              occ;

    logic                             any_eq;
    logic                             any_rng;
    logic [skv_pkg::VAL_W-1:0]        eq_value;
    logic [7:0]                       limit_eff;
    logic                             full;
    logic                             accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // live entries sit in the lowest cells
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            occ[i] = (32'(count_reg) > i);
        end
    end

    // lookup reduction over the row
    always_comb
    begin
        any_eq   = 1'b0;
        any_rng  = 1'b0;
        eq_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_eq   = any_eq | stat[i].eq;
            any_rng  = any_rng | stat[i].in_rng;
            eq_value = eq_value | (stat[i].eq ? cell_value[i] : '0);
        end
    end

    // effective limit saturates at the row length
    always_comb
    begin
        if ({2'b00, limit_reg} > 8'(CAPACITY))
        begin
            limit_eff = 8'(CAPACITY);
        end
        else
        begin
            limit_eff = {2'b00, limit_reg};
        end
        full = (8'(count_reg) >= limit_eff);
    end

    // broadcast to the cell row
    always_comb
    begin
        ctrl.op        = skv_pkg::CELL_HOLD;
        ctrl.req_key   = req_key_reg;
        ctrl.req_value = req_value_reg;
        ctrl.req_end   = req_end_reg;
        case (state_reg)
            ST_EXEC:
            begin
                if (kind_reg == skv_pkg::KIND_PUT && !full)
                begin
                    ctrl.op = skv_pkg::CELL_PUT;
                end
                else if (kind_reg == skv_pkg::KIND_RANGE)
                begin
                    ctrl.op = skv_pkg::CELL_MARK;
                end
            end
            ST_ROT:
            begin
                ctrl.op = skv_pkg::CELL_ROT;
            end
            default:
            begin
                ctrl.op = skv_pkg::CELL_HOLD;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rot_next       = rot_reg;
        res_valid_next = 1'b0;
        hit_next       = 1'b0;
        res_key_next   = '0;
        res_value_next = '0;
        last_next      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                res_valid_next = 1'b1;
                case (kind_reg)
                    skv_pkg::KIND_GET:
                    begin
                        hit_next = any_eq;
                        if (any_eq)
                        begin
                            res_key_next   = req_key_reg;
                            res_value_next = eq_value;
                        end
                    end
                    skv_pkg::KIND_PUT:
                    begin
                        if (!full)
                        begin
                            hit_next = 1'b1;
                            if (!any_eq)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    skv_pkg::KIND_RANGE:
                    begin
                        if (any_rng)
                        begin
                            res_valid_next = 1'b0;
                            state_next     = ST_ROT;
                            rot_next       = '0;
                        end
                    end
                    default:
                    begin
                        count_next = '0;
                        hit_next   = 1'b1;
                    end
                endcase
            end
            ST_ROT:
            begin
                // cell 0 streams out while the row turns once
                res_valid_next = stat[0].mark;
                hit_next       = stat[0].mark;
                res_key_next   = cell_key[0];
                res_value_next = cell_value[0];
                last_next      = !stat[1].mark;
                rot_next       = rot_reg + RCW'(1);
                if (rot_reg == RCW'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rot_reg       <= '0;
            limit_reg     <= skv_pkg::CFG_W'(32);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rot_reg       <= rot_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= kind;
            req_key_reg   <= key;
            req_value_reg <= value;
            req_end_reg   <= range_end;
        end
        hit_reg       <= hit_next;
        res_key_reg   <= res_key_next;
        res_value_reg <= res_value_next;
        last_reg      <= last_next;
    end

    // cell row
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                      p_lt;
            logic [skv_pkg::KEY_W-1:0] p_key;
            logic [skv_pkg::VAL_W-1:0] p_value;
            logic [skv_pkg::KEY_W-1:0] n_key;
            logic [skv_pkg::VAL_W-1:0] n_value;
            logic                      n_mark;

            if (g == 0)
            begin : g_first
                assign p_lt    = 1'b1;
                assign p_key   = '0;
                assign p_value = '0;
            end
            else
            begin : g_mid
                assign p_lt    = stat[g-1].lt;
                assign p_key   = cell_key[g-1];
                assign p_value = cell_value[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_wrap
                assign n_key   = cell_key[0];
                assign n_value = cell_value[0];
                assign n_mark  = 1'b0;
            end
            else
            begin : g_next
                assign n_key   = cell_key[g+1];
                assign n_value = cell_value[g+1];
                assign n_mark  = stat[g+1].mark;
            end

            skv_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .upd        (any_eq),
                .occ        (occ[g]),
                .prev_lt    (p_lt),
                .prev_key   (p_key),
                .prev_value (p_value),
                .next_key   (n_key),
                .next_value (n_value),
                .next_mark  (n_mark),
                .cell_key   (cell_key[g]),
                .cell_value (cell_value[g]),
                .stat       (stat[g])
            );
        end
    endgenerate

    assign result_valid = res_valid_reg;
    assign hit          = hit_reg;
    assign out_key      = res_key_reg;
    assign out_value    = res_value_reg;
    assign last         = last_reg;

endmodule
